>>> rtl/core/dense_graph_shortest_paths_assert.svh
// assertion macros shared by the shortest path block
`ifndef DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DGSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define DGSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DGSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DGSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/dgsp_pkg.sv
// shared types and constants of the shortest path block
package dgsp_pkg;

    localparam int MAX_NODES_DEF    = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int NODE_COUNT_W     = 5;
    localparam int NODE_FIELD_W     = 4;
    localparam int WEIGHT_FIELD_W   = 16;
    localparam int DIST_W           = 20;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 24;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = NODE_COUNT_W'(16);
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_MIN   = NODE_COUNT_W'(2);
    localparam logic [DIST_W-1:0]       DIST_MAX         = {DIST_W{1'b1}};

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // weight write word accepted
        logic issue_init;  // read source row entry at index
        logic issue_relax; // read picked node row entry at index
        logic search;      // min search step at index
        logic take;        // mark picked node visited
        logic emit;        // load output register from distance at index
        logic emit_last;   // final distance of the query
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic found;       // min search found an unvisited node
        logic out_free;    // output register can take a word
    } t_status;

endpackage

>>> rtl/core/dense_graph_shortest_paths.sv
// shortest path distances over a dense weighted adjacency matrix
// load word: taken while idle, ready again right after; a query word with n nodes
//   loads the source row, runs up to n-2 rounds of min search and relax, then emits n
//   output words, paced by one distance read and one matrix read per cycle unless the output stalls
// one item at a time; the next word is taken once the query's last result is registered
// reset (synchronous, active low) returns to idle and sets node count to 16; matrix not cleared
module dense_graph_shortest_paths
    import dgsp_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // node count register
    input  logic                    i_cfg_wr_en,
    input  logic [NODE_COUNT_W-1:0] i_cfg_wr_data,
    // input words
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [S_TDATA_W-1:0]    i_s_tdata,   // row[3:0] col[7:4] weight[23:8] source[27:24]
    input  logic                    i_s_tuser,   // mode: 0 weight load, 1 query
    // result words
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [M_TDATA_W-1:0]    o_m_tdata,   // dest[3:0] distance[23:4]
    output logic                    o_m_tlast
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    t_cmd                      cmd;
    t_status                   status;
    logic [NODE_W-1:0]         idx;
    logic [NODE_W-1:0]         src;
    logic [NODE_FIELD_W-1:0]   in_row;
    logic [NODE_FIELD_W-1:0]   in_col;
    logic [WEIGHT_FIELD_W-1:0] in_weight;
    logic [NODE_FIELD_W-1:0]   in_source;
    logic [NODE_FIELD_W-1:0]   out_dest;
    logic [DIST_W-1:0]         out_distance;

    // unpack the input word, top nibble is padding
    assign in_row    = i_s_tdata[3:0];
    assign in_col    = i_s_tdata[7:4];
    assign in_weight = i_s_tdata[23:8];
    assign in_source = i_s_tdata[27:24];

    // sequencer: node count register, query phases, index and round counters
    dgsp_ctrl #(
        .MAX_NODES (MAX_NODES),
        .NODE_W    (NODE_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_mode        (i_s_tuser),
        .i_source      (in_source),
        .o_s_tready    (o_s_tready),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_idx         (idx),
        .o_src         (src)
    );

    // datapath: weight memory, distance row, min search, relax, output register
    dgsp_datapath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NODE_W      (NODE_W)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .i_src      (src),
        .i_row      (in_row),
        .i_col      (in_col),
        .i_weight   (in_weight),
        .i_m_tready (i_m_tready),
        .o_status   (status),
        .o_valid    (o_m_tvalid),
        .o_dest     (out_dest),
        .o_distance (out_distance),
        .o_last     (o_m_tlast)
    );

    // pack the result word
    assign o_m_tdata = {out_distance, out_dest};

endmodule

>>> rtl/core/dgsp_ctrl.sv
// query sequencer and node count register of the shortest path block
`include "dense_graph_shortest_paths_assert.svh"

module dgsp_ctrl
    import dgsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int NODE_W    = $clog2(MAX_NODES),
    parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [NODE_COUNT_W-1:0] i_cfg_wr_data,
    input  logic                    i_s_tvalid,
    input  logic                    i_mode,
    input  logic [NODE_FIELD_W-1:0] i_source,
    output logic                    o_s_tready,
    input  t_status                 i_status,
    output t_cmd                    o_cmd,
    output logic [NODE_W-1:0]       o_idx,
    output logic [NODE_W-1:0]       o_src
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_RELAX  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_round, n_round;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [NODE_W-1:0]       r_src, n_src;
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [CNT_W-1:0]        n_eff;
    logic                    accept;
    logic                    src_ok;
    logic                    more_rounds;
    logic                    first_round_ok;
    logic                    at_end;
    logic                    at_last;
    logic [CNT_W:0]          round_plus2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_node_count <= i_cfg_wr_data;
        end
    end

    // clamp node count into 2..MAX_NODES
    always_comb begin
        if (r_node_count < NODE_COUNT_MIN) begin
            n_eff = CNT_W'(2);
        end else if (32'(r_node_count) > MAX_NODES) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = CNT_W'(r_node_count);
        end
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign accept         = i_s_tvalid && o_s_tready;
    assign src_ok         = 32'(i_source) < 32'(n_eff);
    assign round_plus2    = {1'b0, r_round} + (CNT_W + 1)'(2);
    // rounds done after this one, plus two, still below node count
    assign more_rounds    = (round_plus2 + (CNT_W + 1)'(1)) < {1'b0, r_n};
    assign first_round_ok = r_n > CNT_W'(2);
    assign at_end         = (r_idx == r_n);
    assign at_last        = (r_idx == r_n - CNT_W'(1));
    assign o_idx          = r_idx[NODE_W-1:0];
    assign o_src          = r_src;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_round = r_round;
        n_n     = r_n;
        n_src   = r_src;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = accept && (i_mode == MODE_LOAD);
                if (accept && (i_mode == MODE_QUERY) && src_ok) begin
                    n_state = S_INIT;
                    n_idx   = '0;
                    n_round = '0;
                    n_n     = n_eff;
                    n_src   = NODE_W'(i_source);
                end
            end
            S_INIT: begin
                o_cmd.issue_init = !at_end;
                n_idx            = r_idx + CNT_W'(1);
                if (at_end) begin
                    n_idx   = '0;
                    n_state = first_round_ok ? S_SEARCH : S_OUT;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_idx        = r_idx + CNT_W'(1);
                if (at_last) begin
                    n_idx   = '0;
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                if ((r_idx == '0) && !i_status.found) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.take        = (r_idx == '0);
                    o_cmd.issue_relax = !at_end;
                    n_idx             = r_idx + CNT_W'(1);
                    if (at_end) begin
                        n_idx   = '0;
                        n_round = r_round + CNT_W'(1);
                        n_state = more_rounds ? S_SEARCH : S_OUT;
                    end
                end
            end
            S_OUT: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_last = at_last;
                if (i_status.out_free) begin
                    n_idx = r_idx + CNT_W'(1);
                    if (at_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_src <= n_src;
    end

    `DGSP_ASSERT_IMPLY(a_search_in_range, i_clk, i_rst_n, r_state == S_SEARCH, r_idx < r_n, "search index past node count")
    `DGSP_ASSERT_NEXT(a_last_ends_query, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE, "query did not end after last word")
    `DGSP_ASSERT_IMPLY(a_round_bound, i_clk, i_rst_n, r_state == S_RELAX, round_plus2 < {1'b0, r_n}, "too many relax rounds")

endmodule

>>> rtl/core/dgsp_datapath.sv
// weight memory, distance row, visit marks and output register
`include "dense_graph_shortest_paths_assert.svh"

module dgsp_datapath
    import dgsp_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    parameter int NODE_W      = $clog2(MAX_NODES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [NODE_W-1:0]         i_idx,
    input  logic [NODE_W-1:0]         i_src,
    input  logic [NODE_FIELD_W-1:0]   i_row,
    input  logic [NODE_FIELD_W-1:0]   i_col,
    input  logic [WEIGHT_FIELD_W-1:0] i_weight,
    input  logic                      i_m_tready,
    output t_status                   o_status,
    output logic                      o_valid,
    output logic [NODE_FIELD_W-1:0]   o_dest,
    output logic [DIST_W-1:0]         o_distance,
    output logic                      o_last
);

    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    localparam logic [1:0] P_NONE  = 2'd0;
    localparam logic [1:0] P_INIT  = 2'd1;
    localparam logic [1:0] P_RELAX = 2'd2;

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic [DIST_W-1:0]      r_dist [MAX_NODES];
    logic [MAX_NODES-1:0]   r_mark;
    logic [1:0]             r_p_op;
    logic [NODE_W-1:0]      r_p_idx;
    logic                   r_found;
    logic [DIST_W-1:0]      r_best_d;
    logic [NODE_W-1:0]      r_best_v;
    logic                   r_o_valid;
    logic [NODE_FIELD_W-1:0] r_o_dest;
    logic [DIST_W-1:0]      r_o_dist;
    logic                   r_o_last;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [NODE_W-1:0]      row_sel;
    logic [NODE_W-1:0]      dist_idx;
    logic [DIST_W-1:0]      dist_rd;
    logic [SUM_W-1:0]       cand_sum;
    logic [DIST_W-1:0]      cand;
    logic [DIST_W-1:0]      init_val;
    logic                   first;
    logic                   better;
    logic                   issue;

    // writes outside the matrix are dropped
    assign wr_en   = i_cmd.load && (32'(i_row) < MAX_NODES) && (32'(i_col) < MAX_NODES);
    assign wr_addr = ADDR_W'(NODE_W'(i_row)) * ADDR_W'(MAX_NODES) + ADDR_W'(NODE_W'(i_col));
    assign row_sel = i_cmd.issue_init ? i_src : r_best_v;
    assign rd_addr = ADDR_W'(row_sel) * ADDR_W'(MAX_NODES) + ADDR_W'(i_idx);
    assign issue   = i_cmd.issue_init || i_cmd.issue_relax;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= WEIGHT_BITS'(i_weight);
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign dist_idx = (r_p_op != P_NONE) ? r_p_idx : i_idx;
    assign dist_rd  = r_dist[dist_idx];

    // saturating candidate and clamped start value
    assign cand_sum = SUM_W'(r_best_d) + SUM_W'(r_rd_data);
    assign cand     = (cand_sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(cand_sum);
    assign init_val = (SUM_W'(r_rd_data) > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(r_rd_data);

    assign first  = (i_idx == '0);
    assign better = r_mark[i_idx] && (first || !r_found || (dist_rd < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_op  <= P_NONE;
            r_mark  <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.issue_init) begin
                r_p_op <= P_INIT;
            end else if (i_cmd.issue_relax) begin
                r_p_op <= P_RELAX;
            end else begin
                r_p_op <= P_NONE;
            end
            if (i_cmd.take) begin
                r_mark[r_best_v] <= 1'b0;
            end
            if (r_p_op == P_INIT) begin
                r_mark[r_p_idx] <= (r_p_idx != i_src);
            end
            if (i_cmd.search) begin
                if (better) begin
                    r_found <= 1'b1;
                end else if (first) begin
                    r_found <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx <= i_idx;
        if (i_cmd.search && better) begin
            r_best_d <= dist_rd;
            r_best_v <= i_idx;
        end
        if (r_p_op == P_INIT) begin
            r_dist[r_p_idx] <= init_val;
        end else if ((r_p_op == P_RELAX) && r_mark[r_p_idx] && (dist_rd > cand)) begin
            r_dist[r_p_idx] <= cand;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_dest <= NODE_FIELD_W'(i_idx);
            r_o_dist <= dist_rd;
            r_o_last <= i_cmd.emit_last;
        end
    end

    assign o_status.found    = r_found;
    assign o_status.out_free = !r_o_valid || i_m_tready;
    assign o_valid           = r_o_valid;
    assign o_dest            = r_o_dest;
    assign o_distance        = r_o_dist;
    assign o_last            = r_o_last;

    `DGSP_ASSERT_NEXT(a_proc_follows_issue, i_clk, i_rst_n, !issue, r_p_op == P_NONE, "row entry processed without a read")
    `DGSP_ASSERT_IMPLY(a_emit_needs_room, i_clk, i_rst_n, i_cmd.emit, o_status.out_free, "output word overwritten")
    `DGSP_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_o_valid && !i_m_tready, r_o_valid, "stalled word dropped")

endmodule
